FILE: hdl/gbw_pkg.sv
`default_nettype none
package gbw_pkg;
  localparam int NumVerticesDef = 16;
  localparam int NodeSlotsDef   = 64;
  localparam int VertexW        = 4;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_BFS    = 2'd1,
    CMD_DFS    = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_A,
    ST_INS_B,
    ST_CLEAR,
    ST_VISIT,
    ST_POP,
    ST_HEAD,
    ST_NODE,
    ST_EMIT,
    ST_FLUSH,
    ST_RESULT
  } state_t;
endpackage
`default_nettype wire

FILE: hdl/graph_bfs_dfs_walker.sv
// Graph walker: keeps an undirected graph as adjacency lists in a node memory
// and answers insert-edge, breadth-first and depth-first walk commands. An
// insert prepends one node to each endpoint's list and gives one result item
// (status 1 when both vertices are in range but fewer than two nodes are
// free). A walk emits the reached vertices in visit order, neighbors newest
// first, and marks the last item with tlast. An insert writes one node in
// ST_INS_A and one in ST_INS_B, then gives its result. A walk first clears
// the visited marks, one mark per cycle, then reads each list node through
// the registered node memory read. Results pass through a one-item output
// register; the walk stalls while it is full.
`default_nettype none
module graph_bfs_dfs_walker #(
  parameter int NUM_VERTICES = gbw_pkg::NumVerticesDef,
  parameter int NODE_SLOTS   = gbw_pkg::NodeSlotsDef
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [15:0] in_tdata,  // command[1:0], first_vertex[5:2], second_vertex[9:6]
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // vertex[3:0], zero fill
  output logic            out_tlast,
  output logic            out_tuser   // status
);
  import gbw_pkg::*;

  localparam int VW = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
  localparam int NW = $clog2(NODE_SLOTS + 1);
  localparam int CW = $clog2(NUM_VERTICES + 1);

  // node memory: link and vertex per slot; list heads and stack as small arrays
  logic [NW+VertexW-1:0] node_mem [NODE_SLOTS];
  logic [NW-1:0]         head_r [NUM_VERTICES];
  logic [VW-1:0]         pend_mem [NUM_VERTICES];
  logic [NW-1:0]         stk_link_r [NUM_VERTICES];
  logic [NUM_VERTICES-1:0] visited_r;

  state_t state_r, state_nxt;
  logic [NW-1:0] used_r;
  logic          is_dfs_r;
  logic          ins_stat_r;  // status of the pending insert result
  logic [VertexW-1:0] a_r, b_r;
  logic [NW-1:0] p_r;
  logic [VW-1:0] qh_r, qt_r;
  logic [CW-1:0] cnt_r;       // queue count or stack depth
  logic [VW-1:0] clr_r;
  logic [NW+VertexW-1:0] rd_r;
  logic [VertexW-1:0] pend_v_r;     // one held result to learn if it is last
  logic          pend_ok_r;
  logic          ob_v_r, ob_last_r, ob_stat_r;
  logic [VertexW-1:0] ob_vert_r;

  wire logic [1:0] in_cmd = in_tdata[1:0];
  wire logic [VertexW-1:0] in_a = in_tdata[5:2];
  wire logic [VertexW-1:0] in_b = in_tdata[9:6];
  wire logic ob_free = !ob_v_r || out_tready;
  wire logic [NW-1:0] lend = NW'(NODE_SLOTS);
  wire logic [NW-1:0] rd_link = rd_r[NW+VertexW-1:VertexW];
  wire logic [VertexW-1:0] rd_vert = rd_r[VertexW-1:0];
  wire logic rd_ok = (32'(rd_vert) < NUM_VERTICES) && !visited_r[VW'(rd_vert)];

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = ob_v_r;
  assign out_tdata  = {4'd0, ob_vert_r};
  assign out_tlast  = ob_last_r;
  assign out_tuser  = ob_stat_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_tvalid) begin
        if (in_cmd == CMD_INSERT) begin
          if (32'(in_a) >= NUM_VERTICES || 32'(in_b) >= NUM_VERTICES ||
              32'(NODE_SLOTS) - 32'(used_r) < 2) state_nxt = ST_RESULT;
          else state_nxt = ST_INS_A;
        end else if (in_cmd != CMD_NONE && 32'(in_a) < NUM_VERTICES) begin
          state_nxt = ST_CLEAR;
        end
      end
      ST_INS_A: state_nxt = ST_INS_B;
      ST_INS_B: state_nxt = ST_RESULT;
      ST_RESULT: if (ob_free) state_nxt = ST_IDLE;
      ST_CLEAR: if (32'(clr_r) == NUM_VERTICES - 1) state_nxt = ST_VISIT;
      ST_VISIT: if (ob_free) state_nxt = ST_HEAD;
      ST_POP: state_nxt = (cnt_r == '0) ? ST_FLUSH : ST_HEAD;
      ST_HEAD: begin
        if (p_r == lend) state_nxt = is_dfs_r ? ST_POP : ST_POP;
        else state_nxt = ST_NODE;
      end
      ST_NODE: state_nxt = ST_EMIT;
      ST_EMIT: if (ob_free || !rd_ok) begin
        if (rd_ok && is_dfs_r) state_nxt = ST_HEAD;
        else state_nxt = ST_HEAD;
      end
      ST_FLUSH: if (ob_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_INS_A)
      node_mem[used_r[$clog2(NODE_SLOTS)-1:0]] <= {head_r[VW'(a_r)], b_r};
    if (state_r == ST_INS_B)
      node_mem[used_r[$clog2(NODE_SLOTS)-1:0]] <= {head_r[VW'(b_r)], a_r};
    rd_r <= node_mem[p_r[$clog2(NODE_SLOTS)-1:0]];
    if (state_r == ST_EMIT && rd_ok && ob_free && !is_dfs_r) pend_mem[qt_r] <= VW'(rd_vert);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      used_r <= '0;
      ob_v_r <= 1'b0;
      pend_ok_r <= 1'b0;
      cnt_r <= '0;
      for (int i = 0; i < NUM_VERTICES; i++) head_r[i] <= lend;
    end else begin
      state_r <= state_nxt;
      if (ob_v_r && out_tready) ob_v_r <= 1'b0;
      case (state_r)
        ST_IDLE: if (in_tvalid) begin
          a_r <= in_a;
          b_r <= in_b;
          is_dfs_r <= (in_cmd == CMD_DFS);
          ins_stat_r <= (32'(in_a) < NUM_VERTICES && 32'(in_b) < NUM_VERTICES);
          clr_r <= '0;
          pend_ok_r <= 1'b0;
        end
        ST_INS_A: begin
          head_r[VW'(a_r)] <= used_r;
          used_r <= used_r + 1'b1;
        end
        ST_INS_B: begin
          head_r[VW'(b_r)] <= used_r;
          used_r <= used_r + 1'b1;
          ins_stat_r <= 1'b0;
        end
        ST_RESULT: if (ob_free) begin
          ob_v_r <= 1'b1;
          ob_vert_r <= '0;
          ob_last_r <= 1'b1;
          ob_stat_r <= ins_stat_r;
        end
        ST_CLEAR: begin
          visited_r[clr_r] <= 1'b0;
          clr_r <= clr_r + 1'b1;
        end
        ST_VISIT: if (ob_free) begin
          visited_r[VW'(a_r)] <= 1'b1;
          pend_v_r <= a_r;
          pend_ok_r <= 1'b1;
          // scan the start list directly; the queue starts empty
          p_r <= head_r[VW'(a_r)];
          stk_link_r[0] <= head_r[VW'(a_r)];
          cnt_r <= is_dfs_r ? CW'(1) : '0;
          qh_r <= '0;
          qt_r <= '0;
        end
        ST_POP: if (cnt_r != '0) begin
          if (is_dfs_r) begin
            p_r <= stk_link_r[VW'(cnt_r - 1'b1)];
          end else begin
            p_r <= head_r[pend_mem[qh_r]];
            qh_r <= (32'(qh_r) == NUM_VERTICES - 1) ? '0 : qh_r + 1'b1;
            cnt_r <= cnt_r - 1'b1;
          end
        end
        ST_HEAD: if (p_r == lend && is_dfs_r) cnt_r <= cnt_r - 1'b1;
        ST_EMIT: if (ob_free || !rd_ok) begin
          p_r <= rd_link;
          if (is_dfs_r) stk_link_r[VW'(cnt_r - 1'b1)] <= rd_link;
          if (rd_ok) begin
            visited_r[VW'(rd_vert)] <= 1'b1;
            ob_v_r <= pend_ok_r;
            ob_vert_r <= pend_v_r;
            ob_last_r <= 1'b0;
            ob_stat_r <= 1'b0;
            pend_v_r <= rd_vert;
            if (is_dfs_r) begin
              stk_link_r[VW'(cnt_r)] <= head_r[VW'(rd_vert)];
              p_r <= head_r[VW'(rd_vert)];
              cnt_r <= cnt_r + 1'b1;
            end else begin
              qt_r <= (32'(qt_r) == NUM_VERTICES - 1) ? '0 : qt_r + 1'b1;
              cnt_r <= cnt_r + 1'b1;
            end
          end
        end
        ST_FLUSH: if (ob_free) begin
          ob_v_r <= 1'b1;
          ob_vert_r <= pend_v_r;
          ob_last_r <= 1'b1;
          ob_stat_r <= 1'b0;
          pend_ok_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // sanity checks
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(used_r) <= NODE_SLOTS) else $error("node count overflow");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= NUM_VERTICES) else $error("queue or stack overflow");
  a_ins_two: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_INS_A |=> state_r == ST_INS_B) else $error("insert split");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("result dropped");
endmodule
`default_nettype wire
